// ===== rtl/core/rpf_pkg.sv =====
// rpf_pkg: shared types, codes and the crc-16 byte update for the packet framer
// used by rpf_front, rpf_back and the top level; no dependencies
`timescale 1ns / 1ps
package rpf_pkg;

   localparam int MsgSizeDefault = 64;
   localparam int QueueDepth     = 2;

   localparam logic [15:0] CrcPoly = 16'h8005;
   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [7:0]  Preamble = 8'hAA;
   localparam logic [7:0]  DummyByte = 8'hFF;

   // configuration register indexes
   localparam logic CSR_OWN_ADDRESS = 1'b0;
   localparam logic CSR_GROUP_ID    = 1'b1;

   typedef enum logic [1:0] {
      CMD_RX_BYTE  = 2'd0,
      CMD_TX_SLOT  = 2'd1,
      CMD_TX_START = 2'd2,
      CMD_REARM    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_HEADER_OK   = 3'd0,
      ST_PAYLOAD     = 3'd1,
      ST_FRAME_OK    = 3'd2,
      ST_REJECTED    = 3'd3,
      ST_SEND_BYTE   = 3'd4,
      ST_SEND_DONE   = 3'd5,
      ST_REARMED     = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_RX_DST  = 3'd1,
      PH_RX_SRC  = 3'd2,
      PH_RX_DATA = 3'd3,
      PH_TX_PRE  = 3'd4,
      PH_TX_HDR  = 3'd5,
      PH_TX_DATA = 3'd6,
      PH_TX_CRC  = 3'd7
   } phase_type;

   // classified word handed from front to back
   typedef struct packed {
      cmd_type    kind;
      logic [7:0] data_byte;
      logic       len_ok;
      logic [6:0] send_len;
      logic [7:0] send_dst;
   } entry_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_i, input logic [7:0] b_i);
      logic [15:0] c;
      logic [7:0]  b;
      logic        top;
      c = crc_i;
      b = b_i;
      for (int k = 0; k < 8; k++) begin
         top = c[15] ^ b[7];
         c = {c[14:0], 1'b0};
         if (top) begin
            c = c ^ CrcPoly;
         end
         b = {b[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/rpf_front.sv =====
// rpf_front: accepts request words, classifies them and holds them in a short queue
// depends on rpf_pkg
`timescale 1ns / 1ps
module rpf_front
   import rpf_pkg::*;
#(
   parameter int MSG_SIZE = MsgSizeDefault
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_tvalid,
   output logic      req_tready,
   input  logic [1:0]  req_tuser,
   input  logic [23:0] req_tdata,
   output logic      head_valid,
   output entry_type head,
   input  logic      pop
);

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam logic [8:0] LenMax  = 9'(MSG_SIZE + 3);
   localparam logic [7:0] SendMax = 8'(MSG_SIZE);

   entry_type           queue_ff [QueueDepth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   entry_type           entry;
   logic                push;
   logic [7:0]          rx_byte;
   logic [6:0]          slen;

   assign req_tready = (count_ff < CntW'(QueueDepth));
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];

   assign rx_byte = req_tdata[7:0];
   assign slen    = req_tdata[14:8];

   always_comb begin
      entry.kind      = cmd_type'(req_tuser);
      entry.data_byte = rx_byte;
      // length byte range check for receive
      entry.len_ok    = (rx_byte >= 8'd4) && ({1'b0, rx_byte} <= LenMax);
      entry.send_len  = ({1'b0, slen} > SendMax) ? 7'(MSG_SIZE) : slen;
      entry.send_dst  = req_tdata[22:15];
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// ===== rtl/core/rpf_back.sv =====
// rpf_back: framing state machine, crc-16 update and the response register
// depends on rpf_pkg; fed by rpf_front
`timescale 1ns / 1ps
module rpf_back
   import rpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  entry_type   head,
   output logic        pop,
   input  logic [7:0]  own_address,
   input  logic [15:0] group_id,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,
   output logic [31:0] rsp_tdata
);

   phase_type   phase_ff, phase_in;
   logic [15:0] crc_ff, crc_in;
   logic [6:0]  position_ff, position_in;
   logic [6:0]  rx_len_ff, rx_len_in;
   logic [7:0]  rx_source_ff, rx_source_in;
   logic [6:0]  tx_len_ff, tx_len_in;
   logic [7:0]  tx_dst_ff, tx_dst_in;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_tuser_ff;
   logic [31:0] rsp_tdata_ff;

   logic        emit;
   status_type  status;
   logic [7:0]  byte_value;
   logic [6:0]  byte_index;
   logic        rx_info;
   logic        taken;

   logic [7:0]  ch;
   logic        dst_ok;
   logic        pos_lt, pos_eq;
   logic [7:0]  hdr_byte;
   logic [6:0]  pos_inc;
   logic [15:0] crc_sel;
   logic [7:0]  crc_byte_sel;
   logic [15:0] crc_next;

   assign pop     = head_valid && (!rsp_valid_ff || rsp_tready);
   assign ch      = head.data_byte;
   assign dst_ok  = (ch == 8'd0) || (ch == own_address);
   assign pos_lt  = (position_ff < rx_len_ff);
   assign pos_eq  = (position_ff == rx_len_ff);
   assign pos_inc = position_ff + 7'd1;

   always_comb begin
      case (position_ff)
         7'd0:    hdr_byte = group_id[15:8];
         7'd1:    hdr_byte = group_id[7:0];
         7'd2:    hdr_byte = {1'b0, tx_len_ff} + 8'd2;
         7'd3:    hdr_byte = tx_dst_ff;
         default: hdr_byte = own_address;
      endcase
   end

   // one shared byte-wide crc unit
   assign crc_sel      = (phase_ff == PH_IDLE) ? CrcInit : crc_ff;
   assign crc_byte_sel = (head.kind == CMD_TX_SLOT && phase_ff == PH_TX_HDR) ? hdr_byte : ch;
   assign crc_next     = crc16_byte(crc_sel, crc_byte_sel);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (head.kind)
         CMD_REARM: phase_in = PH_IDLE;
         CMD_TX_START: begin
            if (phase_ff == PH_IDLE) begin
               phase_in = PH_TX_PRE;
            end
         end
         CMD_RX_BYTE: begin
            unique case (phase_ff)
               PH_IDLE:    phase_in = head.len_ok ? PH_RX_DST : PH_IDLE;
               PH_RX_DST:  phase_in = dst_ok ? PH_RX_SRC : PH_IDLE;
               PH_RX_SRC:  phase_in = PH_RX_DATA;
               PH_RX_DATA: begin
                  if (pos_lt || (pos_eq && ch == crc_ff[15:8])) begin
                     phase_in = PH_RX_DATA;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
               default:    phase_in = PH_IDLE;
            endcase
         end
         CMD_TX_SLOT: begin
            unique case (phase_ff)
               PH_TX_PRE: phase_in = PH_TX_HDR;
               PH_TX_HDR: begin
                  if (pos_inc >= 7'd5) begin
                     phase_in = (tx_len_ff == 7'd0) ? PH_TX_CRC : PH_TX_DATA;
                  end
               end
               PH_TX_DATA: begin
                  if (pos_inc >= tx_len_ff) begin
                     phase_in = PH_TX_CRC;
                  end
               end
               PH_TX_CRC: begin
                  if (position_ff > 7'd2) begin
                     phase_in = PH_IDLE;
                  end
               end
               default:   phase_in = PH_IDLE;
            endcase
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // datapath updates and response fields
   always_comb begin
      crc_in       = crc_ff;
      position_in  = position_ff;
      rx_len_in    = rx_len_ff;
      rx_source_in = rx_source_ff;
      tx_len_in    = tx_len_ff;
      tx_dst_in    = tx_dst_ff;
      emit         = 1'b0;
      status       = ST_REARMED;
      byte_value   = 8'd0;
      byte_index   = 7'd0;
      rx_info      = 1'b0;
      taken        = 1'b0;
      unique case (head.kind)
         CMD_REARM: begin
            emit = 1'b1;
         end
         CMD_TX_START: begin
            if (phase_ff == PH_IDLE) begin
               tx_len_in   = head.send_len;
               tx_dst_in   = head.send_dst;
               position_in = 7'd0;
            end
         end
         CMD_RX_BYTE: begin
            unique case (phase_ff)
               PH_IDLE: begin
                  if (head.len_ok) begin
                     crc_in    = crc_next;
                     rx_len_in = 7'(ch - 8'd2);
                  end else begin
                     emit   = 1'b1;
                     status = ST_REJECTED;
                  end
               end
               PH_RX_DST: begin
                  if (dst_ok) begin
                     crc_in = crc_next;
                  end else begin
                     emit   = 1'b1;
                     status = ST_REJECTED;
                  end
               end
               PH_RX_SRC: begin
                  crc_in       = crc_next;
                  rx_source_in = ch;
                  position_in  = 7'd0;
                  emit         = 1'b1;
                  status       = ST_HEADER_OK;
                  rx_info      = 1'b1;
               end
               PH_RX_DATA: begin
                  emit = 1'b1;
                  if (pos_lt) begin
                     crc_in      = crc_next;
                     position_in = pos_inc;
                     status      = ST_PAYLOAD;
                     byte_value  = ch;
                     byte_index  = position_ff;
                     rx_info     = 1'b1;
                  end else if (pos_eq && ch == crc_ff[15:8]) begin
                     // crc high byte matched, wait for the low byte
                     position_in = pos_inc;
                     emit        = 1'b0;
                  end else if (!pos_eq && ch == crc_ff[7:0]) begin
                     status  = ST_FRAME_OK;
                     rx_info = 1'b1;
                  end else begin
                     status = ST_REJECTED;
                  end
               end
               default: begin
                  emit = 1'b1;
               end
            endcase
         end
         CMD_TX_SLOT: begin
            emit = 1'b1;
            unique case (phase_ff)
               PH_TX_PRE: begin
                  position_in = 7'd0;
                  status      = ST_SEND_BYTE;
                  byte_value  = Preamble;
               end
               PH_TX_HDR: begin
                  // group bytes are outside the crc
                  crc_in      = (position_ff <= 7'd1) ? CrcInit : crc_next;
                  position_in = (pos_inc >= 7'd5) ? 7'd0 : pos_inc;
                  status      = ST_SEND_BYTE;
                  byte_value  = hdr_byte;
               end
               PH_TX_DATA: begin
                  crc_in      = crc_next;
                  position_in = (pos_inc >= tx_len_ff) ? 7'd0 : pos_inc;
                  status      = ST_SEND_BYTE;
                  byte_value  = ch;
                  taken       = 1'b1;
               end
               PH_TX_CRC: begin
                  status      = ST_SEND_BYTE;
                  position_in = pos_inc;
                  case (position_ff)
                     7'd0:    byte_value = crc_ff[15:8];
                     7'd1:    byte_value = crc_ff[7:0];
                     7'd2:    byte_value = DummyByte;
                     default: begin
                        position_in = 7'd0;
                        status      = ST_SEND_DONE;
                     end
                  endcase
               end
               default: begin
                  status = ST_REARMED;
               end
            endcase
         end
         default: begin
            emit = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         crc_ff       <= CrcInit;
         position_ff  <= '0;
         rx_len_ff    <= '0;
         rx_source_ff <= '0;
         tx_len_ff    <= '0;
         tx_dst_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff     <= phase_in;
            crc_ff       <= crc_in;
            position_ff  <= position_in;
            rx_len_ff    <= rx_len_in;
            rx_source_ff <= rx_source_in;
            tx_len_ff    <= tx_len_in;
            tx_dst_ff    <= tx_dst_in;
         end
         if (pop) begin
            rsp_valid_ff <= emit;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_tuser_ff <= status;
         rsp_tdata_ff <= {1'b0, taken,
                          rx_info ? rx_len_ff : 7'd0,
                          rx_info ? rx_source_in : 8'd0,
                          byte_index, byte_value};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ===== rtl/core/radio_packet_framer_crc16_unit.sv =====
// radio packet framer / deframer with crc-16 (poly 0x8005, init 0xffff)
// request channel carries one radio event per word; the response channel
// returns at most one word per event. csr channel sets own address and group.
// path: an accepted request word passes the front queue, then the response
// register, before rsp_tvalid rises and the response word can be taken.
// throughput: one request word per cycle while rsp_tready stays high, set by the
// single framing step and its byte-wide crc update in the back end.
// events that give no response (start transmit, destination or length byte,
// matching crc high byte) still pop the queue and take a step of the back end.
// reset clears the queue, returns the framer to listening with the crc at
// 0xffff and clears own address and group id.
// when the receiver holds rsp_tready low the response register keeps its
// word, the back end stops, and the two-word queue fills before req_tready
// drops; no word is lost. csr_ready is always high; write registers only
// while no event is in flight.
`timescale 1ns / 1ps
module radio_packet_framer_crc16_unit
   import rpf_pkg::*;
#(
   parameter int MSG_SIZE = MsgSizeDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // command
   input  logic [23:0] req_tdata,   // data_byte, send_length, send_destination, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // status
   output logic [31:0] rsp_tdata,   // byte_value, byte_index, source_address,
                                    // frame_length, payload_taken, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   logic [7:0]  own_address_ff;
   logic [15:0] group_id_ff;
   logic        head_valid;
   entry_type   head;
   logic        pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= '0;
         group_id_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OWN_ADDRESS: own_address_ff <= csr_data[7:0];
            CSR_GROUP_ID:    group_id_ff    <= csr_data;
            default:         own_address_ff <= own_address_ff;
         endcase
      end
   end

   rpf_front #(
      .MSG_SIZE (MSG_SIZE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   rpf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .own_address (own_address_ff),
      .group_id    (group_id_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
